FILE: hdl/tone_pwm_divider_select_assert.svh
// Assertion macros shared by the tone divider select block.
`ifndef TONE_PWM_DIVIDER_SELECT_ASSERT_SVH
`define TONE_PWM_DIVIDER_SELECT_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define TPDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone_pwm_divider_select: same-cycle check failed");

// Next-cycle implication, held off while reset is low.
`define TPDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone_pwm_divider_select: next-cycle check failed");

`endif

FILE: hdl/tpds_pkg.sv
// Types and constants of the tone divider select block.
package tpds_pkg;

    localparam int CLOCK_W    = 27;
    localparam int PRESCALE_W = 8;
    localparam int FREQ_W     = 16;
    localparam int DIV_W      = 4;
    localparam int LEVEL_W    = 16;
    localparam int BASE_W     = PRESCALE_W + 1 + FREQ_W;
    localparam int DIVISOR_W  = BASE_W + 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CLOCK_W-1:0]    CLOCK_RESET    = 27'd32000000;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd0;
    localparam logic [DIV_W-1:0]      RESET_DIVIDER  = 4'd2;
    localparam logic [LEVEL_W-1:0]    RESET_LEVEL    = 16'd999;
    localparam logic [CLOCK_W-1:0]    MIN_PERIOD     = 27'd3;

    localparam logic [31:0] DEF_COUNTER_MAX   = 32'd65535;
    localparam int unsigned DEF_DIVIDER_COUNT = 8;

    typedef enum logic {
        REG_CLOCK    = 1'b0,
        REG_PRESCALE = 1'b1
    } t_reg_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    // One classified request as it waits between front and back.
    typedef struct packed {
        logic              silence;
        logic [BASE_W-1:0] base;
    } t_job;

    typedef struct packed {
        logic               applied;
        logic [DIV_W-1:0]   divider_ratio;
        logic [LEVEL_W-1:0] period_load;
        logic [LEVEL_W-1:0] compare_level;
        logic               pwm_active;
        logic               clock_reload;
        logic               tone_started;
    } t_result;

endpackage

FILE: hdl/tpds_front.sv
// Front stage: takes request words, sorts silence from tones, scales by the prescaler.
module tpds_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [tpds_pkg::FREQ_W-1:0]        i_freq_hz,
    input  logic [tpds_pkg::PRESCALE_W-1:0]    i_prescale,
    input  logic                               i_queue_full,
    output logic                               o_push,
    output tpds_pkg::t_job                     o_job
);

    logic                          r_valid;
    logic [tpds_pkg::FREQ_W-1:0]   r_freq;
    logic [tpds_pkg::PRESCALE_W:0] scale;
    logic                          accept;

    assign o_stall = r_valid && i_queue_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_queue_full;

    assign scale         = {1'b0, i_prescale} + {{tpds_pkg::PRESCALE_W{1'b0}}, 1'b1};
    assign o_job.silence = (r_freq == '0);
    assign o_job.base    = tpds_pkg::BASE_W'(scale) * tpds_pkg::BASE_W'(r_freq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_freq <= i_freq_hz;
        end
    end

endmodule

FILE: hdl/tpds_queue.sv
// Short job queue between the front stage and the back sequencer.
module tpds_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpds_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tpds_pkg::t_job o_job
);

    localparam int Depth = tpds_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    tpds_pkg::t_job r_slot [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: hdl/tpds_div.sv
// Restoring divider, one quotient bit per cycle.
module tpds_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tpds_pkg::CLOCK_W-1:0]     i_dividend,
    input  logic [tpds_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [tpds_pkg::CLOCK_W-1:0]     o_quotient
);

    localparam int QW   = tpds_pkg::CLOCK_W;
    localparam int DW   = tpds_pkg::DIVISOR_W;
    localparam int CntW = $clog2(QW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [QW-1:0]   r_quo;
    logic [DW-1:0]   r_divisor;
    logic [DW+1:0]   trial;
    logic            fits;

    // The remainder stays below the divisor, so a kept difference fits in DW bits.
    assign trial = {1'b0, r_rem, r_quo[QW-1]} - {2'b00, r_divisor};
    assign fits  = !trial[DW+1];

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[DW-1:0] : {r_rem[DW-2:0], r_quo[QW-1]};
            r_quo <= {r_quo[QW-2:0], fits};
        end
    end

endmodule

FILE: hdl/tpds_back.sv
// Back sequencer: walks the dividers, keeps the tone state and holds the result word.
module tpds_back #(
    parameter logic [31:0] COUNTER_MAX   = tpds_pkg::DEF_COUNTER_MAX,
    parameter int unsigned DIVIDER_COUNT = tpds_pkg::DEF_DIVIDER_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  tpds_pkg::t_job                i_job,
    output logic                          o_pop,
    input  logic [tpds_pkg::CLOCK_W-1:0]  i_clock_hz,
    output logic                          o_valid,
    input  logic                          i_stall,
    output tpds_pkg::t_result             o_result
);

    localparam int CW = tpds_pkg::CLOCK_W;
    localparam int DW = tpds_pkg::DIVISOR_W;
    localparam int VW = tpds_pkg::DIV_W;
    localparam int LW = tpds_pkg::LEVEL_W;
    localparam logic [VW-1:0] DivLast = VW'(DIVIDER_COUNT);

    tpds_pkg::t_back_state r_state, n_state;
    logic [VW-1:0]        r_div, n_div;
    logic [DW-1:0]        r_divisor, n_divisor;
    logic [tpds_pkg::BASE_W-1:0] r_base, n_base;
    logic                 r_running, n_running;
    logic [VW-1:0]        r_divider_now, n_divider_now;
    logic [LW-1:0]        r_load_now, n_load_now;
    logic [LW-1:0]        r_compare_now, n_compare_now;
    logic                 r_applied, n_applied;
    logic                 r_reload, n_reload;
    logic                 r_started, n_started;
    logic                 r_out_valid, n_out_valid;
    tpds_pkg::t_result    r_out, n_out;

    logic                 div_start;
    logic                 div_done;
    logic [CW-1:0]        quotient;
    logic [CW-1:0]        period;
    logic [CW-1:0]        load;
    logic                 load_fits;
    logic                 out_free;

    tpds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_clock_hz),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign period    = (quotient < tpds_pkg::MIN_PERIOD) ? tpds_pkg::MIN_PERIOD : quotient;
    assign load      = period - 1'b1;
    assign load_fits = ({{(32 - CW){1'b0}}, load} <= COUNTER_MAX);
    assign out_free  = !r_out_valid || !i_stall;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state       = r_state;
        n_div         = r_div;
        n_divisor     = r_divisor;
        n_base        = r_base;
        n_running     = r_running;
        n_divider_now = r_divider_now;
        n_load_now    = r_load_now;
        n_compare_now = r_compare_now;
        n_applied     = r_applied;
        n_reload      = r_reload;
        n_started     = r_started;
        n_out_valid   = r_out_valid && i_stall;
        n_out         = r_out;
        o_pop         = 1'b0;
        div_start     = 1'b0;

        unique case (r_state)
            tpds_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    if (i_job.silence) begin
                        n_running = 1'b0;
                        n_applied = 1'b1;
                        n_reload  = 1'b0;
                        n_started = 1'b0;
                        n_state   = tpds_pkg::ST_EMIT;
                    end else begin
                        n_div     = VW'(1);
                        n_divisor = DW'(i_job.base);
                        n_base    = i_job.base;
                        n_state   = tpds_pkg::ST_LAUNCH;
                    end
                end
            end
            tpds_pkg::ST_LAUNCH: begin
                div_start = 1'b1;
                n_state   = tpds_pkg::ST_DIV;
            end
            tpds_pkg::ST_DIV: begin
                if (div_done) begin
                    if (load_fits) begin
                        n_reload      = (r_divider_now != r_div);
                        n_divider_now = r_div;
                        n_load_now    = load[LW-1:0];
                        n_compare_now = load[LW:1];
                        n_started     = !r_running;
                        n_running     = 1'b1;
                        n_applied     = 1'b1;
                        n_state       = tpds_pkg::ST_EMIT;
                    end else if (r_div == DivLast) begin
                        n_applied = 1'b0;
                        n_reload  = 1'b0;
                        n_started = 1'b0;
                        n_state   = tpds_pkg::ST_EMIT;
                    end else begin
                        // Next divider: the divisor grows by one more scaled frequency.
                        n_div     = r_div + 1'b1;
                        n_divisor = r_divisor + DW'(r_base);
                        n_state   = tpds_pkg::ST_LAUNCH;
                    end
                end
            end
            tpds_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.applied       = r_applied;
                    n_out.divider_ratio = r_divider_now;
                    n_out.period_load   = r_load_now;
                    n_out.compare_level = r_compare_now;
                    n_out.pwm_active    = r_running;
                    n_out.clock_reload  = r_reload;
                    n_out.tone_started  = r_started;
                    n_state             = tpds_pkg::ST_IDLE;
                end
            end
            default: n_state = tpds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tpds_pkg::ST_IDLE;
            r_running     <= 1'b0;
            r_divider_now <= tpds_pkg::RESET_DIVIDER;
            r_load_now    <= tpds_pkg::RESET_LEVEL;
            r_compare_now <= tpds_pkg::RESET_LEVEL;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_running     <= n_running;
            r_divider_now <= n_divider_now;
            r_load_now    <= n_load_now;
            r_compare_now <= n_compare_now;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div     <= n_div;
        r_divisor <= n_divisor;
        r_base    <= n_base;
        r_applied <= n_applied;
        r_reload  <= n_reload;
        r_started <= n_started;
        r_out     <= n_out;
    end

endmodule

FILE: hdl/tone_pwm_divider_select.sv
// Top level of the tone divider select block: register port, front, queue and back.
//
//   channel   direction  handshake                  word
//   request   in         i_in_valid / o_in_stall    i_freq_hz
//   result    out        o_out_valid / i_out_stall  o_applied .. o_tone_started
//   config    in         psel, penable, pwrite      clock_hz at 0x0, prescale at 0x4
//
// A silence word skips the divider: the back sequencer goes from idle straight to emit.
// A tone word runs the serial divider once per tried divider until one fits
// (up to DIVIDER_COUNT, 8 by default); an unreachable tone tries all of them.
// Reset is synchronous and active low; it restores the registers and the tone state.
// Two request words can wait in the queue while a result is stalled at the output.
module tone_pwm_divider_select #(
    parameter logic [31:0] COUNTER_MAX   = tpds_pkg::DEF_COUNTER_MAX,
    parameter int unsigned DIVIDER_COUNT = tpds_pkg::DEF_DIVIDER_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tpds_pkg::FREQ_W-1:0]   i_freq_hz,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_applied,
    output logic [tpds_pkg::DIV_W-1:0]    o_divider_ratio,
    output logic [tpds_pkg::LEVEL_W-1:0]  o_period_load,
    output logic [tpds_pkg::LEVEL_W-1:0]  o_compare_level,
    output logic                          o_pwm_active,
    output logic                          o_clock_reload,
    output logic                          o_tone_started,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [tpds_pkg::CLOCK_W-1:0]    r_clock_hz;
    logic [tpds_pkg::PRESCALE_W-1:0] r_prescale;
    logic                            cfg_write;
    tpds_pkg::t_reg_sel              reg_sel;

    logic               push;
    logic               queue_full;
    tpds_pkg::t_job     front_job;
    logic               q_valid;
    logic               q_pop;
    tpds_pkg::t_job     q_job;
    tpds_pkg::t_result  result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = tpds_pkg::t_reg_sel'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            tpds_pkg::REG_CLOCK:    prdata = {{(32 - tpds_pkg::CLOCK_W){1'b0}}, r_clock_hz};
            tpds_pkg::REG_PRESCALE: prdata = {{(32 - tpds_pkg::PRESCALE_W){1'b0}}, r_prescale};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= tpds_pkg::CLOCK_RESET;
            r_prescale <= tpds_pkg::PRESCALE_RESET;
        end else if (cfg_write) begin
            if (reg_sel == tpds_pkg::REG_CLOCK) begin
                r_clock_hz <= pwdata[tpds_pkg::CLOCK_W-1:0];
            end else begin
                r_prescale <= pwdata[tpds_pkg::PRESCALE_W-1:0];
            end
        end
    end

    tpds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_freq_hz    (i_freq_hz),
        .i_prescale   (r_prescale),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    tpds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    tpds_back #(
        .COUNTER_MAX   (COUNTER_MAX),
        .DIVIDER_COUNT (DIVIDER_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .i_clock_hz  (r_clock_hz),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_result    (result)
    );

    assign o_applied       = result.applied;
    assign o_divider_ratio = result.divider_ratio;
    assign o_period_load   = result.period_load;
    assign o_compare_level = result.compare_level;
    assign o_pwm_active    = result.pwm_active;
    assign o_clock_reload  = result.clock_reload;
    assign o_tone_started  = result.tone_started;

`include "tone_pwm_divider_select_assert.svh"

    // A start from idle is only reported for a carried-out tone.
    `TPDS_ASSERT_IMPL(a_start_is_tone, i_clk, i_rst_n, o_out_valid && o_tone_started, o_applied && o_pwm_active)
    // A refused request reports no side effects.
    `TPDS_ASSERT_IMPL(a_refused_quiet, i_clk, i_rst_n, o_out_valid && !o_applied, !o_clock_reload && !o_tone_started)
    // The divider in use is always one of the tried candidates.
    `TPDS_ASSERT_IMPL(a_divider_range, i_clk, i_rst_n, o_out_valid, (o_divider_ratio != 4'd0) && (o_divider_ratio <= 4'd8))
    // The back sequencer leaves idle after taking a job, so it never pops twice in a row.
    `TPDS_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, q_pop, !q_pop)

endmodule
